// ----- rtl/core/ilb_pkg.sv -----
// ilb_pkg: shared types and constants for the indexed insert/erase list buffer
// command and status codes, cell control word, default sizes
// no dependencies
package ilb_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int READ_W         = 32;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_WRITE  = 3'd5,
        CMD_RESIZE = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // broadcast to every cell in the execute cycle
    typedef struct packed {
        logic go;
        cmd_t op;
    } ctl_t;

endpackage

// ----- rtl/core/ilb_cell.sv -----
// ilb_cell: one storage cell of the list buffer chain
// holds one word, takes from its left or right neighbor on insert/erase
// depends on ilb_pkg
module ilb_cell #(
    parameter int WORD_WIDTH = ilb_pkg::WORD_WIDTH_DEF,
    parameter int CW         = 7
) (
    input  logic                  clk,
    input  ilb_pkg::ctl_t         ctl,
    input  logic [CW-1:0]         pos,
    input  logic [CW-1:0]         idx,
    input  logic [CW-1:0]         count,
    input  logic [WORD_WIDTH-1:0] value_word,
    input  logic [WORD_WIDTH-1:0] left_word,
    input  logic [WORD_WIDTH-1:0] right_word,
    output logic [WORD_WIDTH-1:0] word,
    output logic [WORD_WIDTH-1:0] tap
);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic [WORD_WIDTH-1:0] tap_reg;
    logic [WORD_WIDTH-1:0] tap_next;

    always_comb
    begin
        word_next = word_reg;
        tap_next  = '0;
        if (ctl.go)
        begin
            unique case (ctl.op)
                ilb_pkg::CMD_PUSH:
                begin
                    if (pos == count)
                        word_next = value_word;
                end
                ilb_pkg::CMD_POP:
                begin
                    word_next = word_reg;
                end
                ilb_pkg::CMD_INSERT:
                begin
                    // everything above the slot moves up one place
                    if (pos == idx)
                        word_next = value_word;
                    else if (pos > idx)
                        word_next = left_word;
                end
                ilb_pkg::CMD_ERASE:
                begin
                    if (pos >= idx)
                        word_next = right_word;
                end
                ilb_pkg::CMD_READ:
                begin
                    if (pos == idx)
                        tap_next = word_reg;
                end
                ilb_pkg::CMD_WRITE:
                begin
                    if (pos == idx)
                        word_next = value_word;
                end
                ilb_pkg::CMD_RESIZE:
                begin
                    // fill only the newly grown slots
                    if (pos >= count && pos < idx)
                        word_next = value_word;
                end
                default:
                begin
                    word_next = word_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        tap_reg  <= tap_next;
    end

    assign word = word_reg;
    assign tap  = tap_reg;

endmodule

// ----- rtl/core/indexed_insert_erase_list_buffer_unit.sv -----
// indexed_insert_erase_list_buffer_unit: top level of the list buffer
// command sequencer, live count and a row of ilb_cell storage cells
// depends on ilb_pkg and ilb_cell
//
//  channel   ports                          handshake
//  command   cmd, index, value              start, busy (taken when start && !busy)
//  result    status, read_value, count      done (one-cycle strobe, no backpressure)
//
// every command is latched in the idle state, then all cells shift, fill or write in
// parallel in the execute state, and the gather state moves the read word from the
// cell taps into the result registers. done is high in the cycle after the gather state,
// when busy is already low again. reset clears the count and the sequencer only;
// cell contents are undefined until written. results cannot be stalled.
module indexed_insert_erase_list_buffer_unit #(
    parameter int DEPTH      = ilb_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = ilb_pkg::WORD_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  cmd,
    input  logic [CW-1:0]               index,
    input  logic [ilb_pkg::VALUE_W-1:0] value,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [ilb_pkg::READ_W-1:0]  read_value,
    output logic [CW-1:0]               count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GATHER
    } state_t;

    state_t                      state_reg;
    ilb_pkg::cmd_t               op_reg;
    logic [CW-1:0]               idx_reg;
    logic [ilb_pkg::VALUE_W-1:0] val_reg;
    logic [CW-1:0]               count_reg;
    ilb_pkg::status_t            st_reg;
    ilb_pkg::status_t            st_next;
    logic [CW-1:0]               count_next;
    logic                        done_reg;
    logic [1:0]                  status_reg;
    logic [ilb_pkg::READ_W-1:0]  read_value_reg;
    logic [CW-1:0]               count_out_reg;

    ilb_pkg::ctl_t               ctl;
    logic [WORD_WIDTH-1:0]       value_word;
    logic [WORD_WIDTH-1:0]       words [DEPTH];
    logic [WORD_WIDTH-1:0]       taps  [DEPTH];
    logic [WORD_WIDTH-1:0]       tap_or;
    logic [ilb_pkg::READ_W-1:0]  tap_read;

    // status and new count of the latched command
    always_comb
    begin
        st_next    = ilb_pkg::ST_OK;
        count_next = count_reg;
        unique case (op_reg)
            ilb_pkg::CMD_PUSH:
            begin
                if (count_reg >= CW'(DEPTH))
                    st_next = ilb_pkg::ST_FULL;
                else
                    count_next = count_reg + CW'(1);
            end
            ilb_pkg::CMD_POP:
            begin
                if (count_reg == '0)
                    st_next = ilb_pkg::ST_EMPTY;
                else
                    count_next = count_reg - CW'(1);
            end
            ilb_pkg::CMD_INSERT:
            begin
                if (count_reg >= CW'(DEPTH))
                    st_next = ilb_pkg::ST_FULL;
                else if (idx_reg > count_reg)
                    st_next = ilb_pkg::ST_RANGE;
                else
                    count_next = count_reg + CW'(1);
            end
            ilb_pkg::CMD_ERASE:
            begin
                if (count_reg == '0)
                    st_next = ilb_pkg::ST_EMPTY;
                else if (idx_reg >= count_reg)
                    st_next = ilb_pkg::ST_RANGE;
                else
                    count_next = count_reg - CW'(1);
            end
            ilb_pkg::CMD_READ,
            ilb_pkg::CMD_WRITE:
            begin
                if (idx_reg >= count_reg)
                    st_next = ilb_pkg::ST_RANGE;
            end
            ilb_pkg::CMD_RESIZE:
            begin
                if (idx_reg > CW'(DEPTH))
                    st_next = ilb_pkg::ST_FULL;
                else
                    count_next = idx_reg;
            end
            default:
            begin
                st_next = ilb_pkg::ST_RANGE;
            end
        endcase
    end

    assign ctl.go = (state_reg == S_EXEC) && (st_next == ilb_pkg::ST_OK);
    assign ctl.op = op_reg;

    generate
        if (WORD_WIDTH >= ilb_pkg::VALUE_W)
        begin : g_wide
            assign value_word = WORD_WIDTH'(val_reg);
            assign tap_read   = tap_or[ilb_pkg::READ_W-1:0];
        end
        else
        begin : g_narrow
            assign value_word = val_reg[WORD_WIDTH-1:0];
            assign tap_read   = ilb_pkg::READ_W'(tap_or);
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] left_w;
            logic [WORD_WIDTH-1:0] right_w;

            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = words[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = words[gi+1];
            end

            ilb_cell #(
                .WORD_WIDTH (WORD_WIDTH),
                .CW         (CW)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (CW'(gi)),
                .idx        (idx_reg),
                .count      (count_reg),
                .value_word (value_word),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (words[gi]),
                .tap        (taps[gi])
            );
        end
    endgenerate

    // at most one tap is nonzero, so an or gathers the read word
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++)
            tap_or = tap_or | taps[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        op_reg    <= ilb_pkg::cmd_t'(cmd);
                        idx_reg   <= index;
                        val_reg   <= value;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    st_reg    <= st_next;
                    count_reg <= count_next;
                    state_reg <= S_GATHER;
                end
                S_GATHER:
                begin
                    done_reg       <= 1'b1;
                    status_reg     <= st_reg;
                    count_out_reg  <= count_reg;
                    read_value_reg <= tap_read;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;

    // live count never goes past capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("live count beyond capacity");

    // an accepted command always reaches the execute cycle next
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_EXEC))
        else $error("accepted command did not execute");

    // the result strobe comes only out of the gather cycle
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg == S_GATHER))
        else $error("result strobe without gather cycle");

    // a successful push or insert grows the list by exactly one
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.go && (op_reg == ilb_pkg::CMD_PUSH || op_reg == ilb_pkg::CMD_INSERT))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push or insert did not grow the count by one");

    // a failed command never returns a read word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ilb_pkg::ST_OK) |-> (read_value_reg == '0))
        else $error("read word on failed command");

endmodule

// ----- dv/tb_indexed_insert_erase_list_buffer_unit.sv -----
// tb_indexed_insert_erase_list_buffer_unit: self-checking bench for the list buffer unit
// a shadow copy of the list predicts status, read word and count per command word
// depends on ilb_pkg and indexed_insert_erase_list_buffer_unit
module tb_indexed_insert_erase_list_buffer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LIST_DEPTH  = ilb_pkg::DEPTH_DEF;
    localparam int         IDX_W       = $clog2(LIST_DEPTH + 1);
    localparam logic [2:0] CMD_UNKNOWN = 3'd7;
    localparam int         PHASE_WORDS = 470;

    typedef struct {
        ilb_pkg::status_t           status;
        logic [ilb_pkg::READ_W-1:0] read_value;
        logic [IDX_W-1:0]           count;
    } list_answer_t;

    // shadow of the list contents plus the answers still owed by the block
    class list_shadow;
        logic [ilb_pkg::WORD_WIDTH_DEF-1:0] entries [LIST_DEPTH];
        int unsigned                        live;
        list_answer_t                       awaited [$];
        int unsigned                        op_seen [8];
        int unsigned                        checked;
        int unsigned                        failures;

        function new();
            live     = 0;
            checked  = 0;
            failures = 0;
            foreach (op_seen[k])
                op_seen[k] = 0;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void apply_command(logic [2:0] op, logic [IDX_W-1:0] idx,
                                    logic [ilb_pkg::VALUE_W-1:0] word);
            list_answer_t ans;
            int unsigned  k;
            ans.status     = ilb_pkg::ST_OK;
            ans.read_value = '0;
            case (op)
                ilb_pkg::CMD_PUSH:
                    if (live >= LIST_DEPTH)
                        ans.status = ilb_pkg::ST_FULL;
                    else
                    begin
                        entries[live] = word;
                        live++;
                    end
                ilb_pkg::CMD_POP:
                    if (live == 0)
                        ans.status = ilb_pkg::ST_EMPTY;
                    else
                        live--;
                ilb_pkg::CMD_INSERT:
                    // full wins over a bad position
                    if (live >= LIST_DEPTH)
                        ans.status = ilb_pkg::ST_FULL;
                    else if (idx > live)
                        ans.status = ilb_pkg::ST_RANGE;
                    else
                    begin
                        for (k = live; k > idx; k--)
                            entries[k] = entries[k-1];
                        entries[idx] = word;
                        live++;
                    end
                ilb_pkg::CMD_ERASE:
                    if (live == 0)
                        ans.status = ilb_pkg::ST_EMPTY;
                    else if (idx >= live)
                        ans.status = ilb_pkg::ST_RANGE;
                    else
                    begin
                        for (k = idx; k + 1 < live; k++)
                            entries[k] = entries[k+1];
                        live--;
                    end
                ilb_pkg::CMD_READ:
                    if (idx >= live)
                        ans.status = ilb_pkg::ST_RANGE;
                    else
                        ans.read_value = entries[idx];
                ilb_pkg::CMD_WRITE:
                    if (idx >= live)
                        ans.status = ilb_pkg::ST_RANGE;
                    else
                        entries[idx] = word;
                ilb_pkg::CMD_RESIZE:
                    if (idx > LIST_DEPTH)
                        ans.status = ilb_pkg::ST_FULL;
                    else
                    begin
                        for (k = live; k < idx; k++)
                            entries[k] = word;
                        live = idx;
                    end
                default:
                    ans.status = ilb_pkg::ST_RANGE;
            endcase
            ans.count = IDX_W'(live);
            awaited   = {awaited, ans};
            op_seen[op]++;
        endfunction

        function void compare_result(logic [1:0] st, logic [ilb_pkg::READ_W-1:0] rv,
                                     logic [IDX_W-1:0] cnt);
            list_answer_t ans;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result status %0d read %h count %0d",
                             $realtime, st, rv, cnt);
                return;
            end
            ans = awaited.pop_front();
            checked++;
            if (st !== ans.status || rv !== ans.read_value || cnt !== ans.count)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch exp status %0d read %h count %0d, got %0d %h %0d",
                             $realtime, ans.status, ans.read_value, ans.count, st, rv, cnt);
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [2:0]                  cmd   = '0;
    logic [IDX_W-1:0]            index = '0;
    logic [ilb_pkg::VALUE_W-1:0] value = '0;
    logic                        done;
    logic [1:0]                  status;
    logic [ilb_pkg::READ_W-1:0]  read_value;
    logic [IDX_W-1:0]            count;

    list_shadow  shadow = new();
    int unsigned sender_idle_pct = 0;

    indexed_insert_erase_list_buffer_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .index      (index),
        .value      (value),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.compare_result(status, read_value, count);
    end

    // start stays high between back-to-back words, it only drops during a gap
    task automatic send_command(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                input logic [ilb_pkg::VALUE_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= op;
        index <= idx;
        value <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.apply_command(op, idx, word);
    endtask

    task automatic drain_results();
        int unsigned guard;
        guard = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (shadow.outstanding() != 0 && guard < 1000);
    endtask

    // mostly positions that make sense for the current length, some stray ones
    task automatic random_command(output logic [2:0] op, output logic [IDX_W-1:0] idx,
                                  output logic [ilb_pkg::VALUE_W-1:0] word);
        int unsigned n;
        int unsigned roll;
        n    = shadow.live;
        roll = $urandom_range(99);
        if (roll < 16)
            op = ilb_pkg::CMD_PUSH;
        else if (roll < 28)
            op = ilb_pkg::CMD_POP;
        else if (roll < 46)
            op = ilb_pkg::CMD_INSERT;
        else if (roll < 60)
            op = ilb_pkg::CMD_ERASE;
        else if (roll < 76)
            op = ilb_pkg::CMD_READ;
        else if (roll < 88)
            op = ilb_pkg::CMD_WRITE;
        else if (roll < 97)
            op = ilb_pkg::CMD_RESIZE;
        else
            op = CMD_UNKNOWN;

        roll = $urandom_range(99);
        if (roll < 8)
            idx = IDX_W'($urandom_range(LIST_DEPTH));
        else if (roll < 10)
            idx = IDX_W'($urandom_range((1 << IDX_W) - 1));
        else if (op == ilb_pkg::CMD_RESIZE)
        begin
            roll = $urandom_range(99);
            if (roll < 20)
                idx = IDX_W'(LIST_DEPTH);
            else if (roll < 35)
                idx = '0;
            else
                idx = IDX_W'($urandom_range(LIST_DEPTH));
        end
        else if (op == ilb_pkg::CMD_INSERT)
            idx = IDX_W'($urandom_range(n));
        else
            idx = (n == 0) ? '0 : IDX_W'($urandom_range(n - 1));

        roll = $urandom_range(99);
        if (roll < 10)
            word = '0;
        else if (roll < 20)
            word = '1;
        else
            word = $urandom;
    endtask

    initial
    begin
        logic [2:0]                  op;
        logic [IDX_W-1:0]            idx;
        logic [ilb_pkg::VALUE_W-1:0] word;
        int unsigned                 total;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 29;
        // empty list corners
        send_command(ilb_pkg::CMD_POP,     '0, '0);
        send_command(ilb_pkg::CMD_ERASE,   '0, '0);
        send_command(ilb_pkg::CMD_READ,    '0, '0);
        send_command(ilb_pkg::CMD_WRITE,   '0, 32'h1234_5678);
        send_command(ilb_pkg::CMD_INSERT,  IDX_W'(1), 32'hDEAD_BEEF);
        send_command(ilb_pkg::CMD_PUSH,    '0, '1);
        send_command(ilb_pkg::CMD_PUSH,    '0, '0);
        send_command(ilb_pkg::CMD_INSERT,  '0, 32'h5555_5555);
        send_command(ilb_pkg::CMD_INSERT,  IDX_W'(3), 32'hAAAA_AAAA);
        send_command(ilb_pkg::CMD_ERASE,   IDX_W'(4), '0);
        send_command(ilb_pkg::CMD_READ,    IDX_W'(4), '0);
        send_command(ilb_pkg::CMD_WRITE,   IDX_W'(1), 32'h0F0F_0F0F);
        send_command(ilb_pkg::CMD_READ,    IDX_W'(1), '0);
        send_command(ilb_pkg::CMD_ERASE,   '0, '0);
        send_command(CMD_UNKNOWN,          IDX_W'(2), '1);
        // full list corners
        send_command(ilb_pkg::CMD_RESIZE,  IDX_W'(LIST_DEPTH), 32'hA5A5_5A5A);
        send_command(ilb_pkg::CMD_PUSH,    '0, 32'h1111_1111);
        send_command(ilb_pkg::CMD_INSERT,  '1, 32'h2222_2222);
        send_command(ilb_pkg::CMD_RESIZE,  IDX_W'(LIST_DEPTH + 1), '0);
        send_command(ilb_pkg::CMD_RESIZE,  '1, '0);
        send_command(ilb_pkg::CMD_READ,    IDX_W'(LIST_DEPTH - 1), '0);
        send_command(ilb_pkg::CMD_READ,    IDX_W'(2), '0);
        send_command(ilb_pkg::CMD_ERASE,   IDX_W'(LIST_DEPTH - 1), '0);
        send_command(ilb_pkg::CMD_RESIZE,  '0, '1);
        send_command(ilb_pkg::CMD_RESIZE,  IDX_W'(3), 32'hC3C3_C3C3);
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 77 : 0;
            repeat (PHASE_WORDS)
            begin
                random_command(op, idx, word);
                send_command(op, idx, word);
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (shadow.outstanding() != 0)
        begin
            $display("%0d results never arrived", shadow.outstanding());
            shadow.failures += shadow.outstanding();
        end

        total = 0;
        foreach (shadow.op_seen[k])
            total += shadow.op_seen[k];
        $display("%0d command words: push %0d pop %0d insert %0d erase %0d read %0d",
                 total, shadow.op_seen[ilb_pkg::CMD_PUSH], shadow.op_seen[ilb_pkg::CMD_POP],
                 shadow.op_seen[ilb_pkg::CMD_INSERT], shadow.op_seen[ilb_pkg::CMD_ERASE],
                 shadow.op_seen[ilb_pkg::CMD_READ]);
        $display("write %0d resize %0d unknown %0d, %0d results checked, %0d failures",
                 shadow.op_seen[ilb_pkg::CMD_WRITE], shadow.op_seen[ilb_pkg::CMD_RESIZE],
                 shadow.op_seen[CMD_UNKNOWN], shadow.checked, shadow.failures);
        if (shadow.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
